// ===== src/fba_pkg.sv =====
// ----------------------------------------------------------------------------
// fba_pkg
// Shared types and codes for the fit block allocator: item kinds, placement
// policies, result status codes, register map and control structs.
// ----------------------------------------------------------------------------
package fba_pkg;

	// Fixed field widths on the channels
	localparam int SIZE_IN_W = 16;
	localparam int BLK_W     = 4;

	// Item kinds
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_LOAD  = 1'b1;

	// Placement policies (the unused code acts as first fit)
	localparam logic [1:0] MODE_FIRST = 2'd0;
	localparam logic [1:0] MODE_BEST  = 2'd1;
	localparam logic [1:0] MODE_WORST = 2'd2;

	// Result status
	typedef enum logic [1:0] {
		ST_ALLOC = 2'd0,
		ST_NOFIT = 2'd1,
		ST_LOAD  = 2'd2
	} status_t;

	// Register map: register index is paddr[2]
	localparam int         PADDR_W      = 3;
	localparam logic       REG_FIT_MODE = 1'b0;
	localparam logic       REG_BLOCKS   = 1'b1;
	localparam logic [4:0] BLOCKS_RESET = 5'd16;

	// Configuration seen by the sequencer
	typedef struct packed {
		logic [1:0] fit_mode;
		logic [4:0] blocks_in_use;
	} cfg_t;

	// Block store port strobes
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} store_ctl_t;

endpackage

// ===== src/fba_if.sv =====
// ----------------------------------------------------------------------------
// fba_in_if / fba_out_if
// Valid/ready channels of the fit block allocator: request items in,
// result items out.
// ----------------------------------------------------------------------------
interface fba_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [3:0]  block_index;
	logic [15:0] size_value;

	modport source (output valid, cmd, block_index, size_value, input ready);
	modport sink   (input valid, cmd, block_index, size_value, output ready);
endinterface

interface fba_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [3:0]  chosen_block;
	logic [15:0] remaining;

	modport source (output valid, status, chosen_block, remaining, input ready);
	modport sink   (input valid, status, chosen_block, remaining, output ready);
endinterface

// ===== src/fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// fit_block_allocator
// First / best / worst fit placement over a set of memory blocks with
// per-block free capacity, loaded and allocated by request transactions.
//
//   channel   dir  handshake        payload
//   in_ch     in   valid/ready      cmd, block_index, size_value
//   out_ch    out  valid/ready      status, chosen_block, remaining
//   apb       in   psel/penable     paddr, pwdata -> prdata (pready tied high)
//
// A load transaction goes straight to write-back and result; an allocate
// first scans the active blocks, with one store read and one fit compare
// per cycle plus a final compare cycle to drain the read.
// One transaction is in work at a time; in_ch.ready is high only when idle.
// A finished result sits in the output register while the next transaction
// is accepted; a stalled output holds the sequencer before its final step.
// Reset is asynchronous, active low, and makes every block read as zero.
// ----------------------------------------------------------------------------
module fit_block_allocator import fba_pkg::*; #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	fba_in_if.sink             in_ch,
	fba_out_if.source          out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

	cfg_t                 cfg;
	store_ctl_t           st_ctl;
	logic [IDX_W-1:0]     rd_addr;
	logic [IDX_W-1:0]     wr_addr;
	logic [SIZE_BITS-1:0] wr_data;
	logic [SIZE_BITS-1:0] rd_data;

	fba_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fba_store #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.SIZE_BITS  (SIZE_BITS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (st_ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	fba_seq #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.SIZE_BITS  (SIZE_BITS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.cfg     (cfg),
		.st_ctl  (st_ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	// scan reads and write-back never share a cycle
	a_rd_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(st_ctl.rd_en && st_ctl.wr_en))
		else $error("store read and write in the same cycle");

	// store traffic only while a transaction is in work
	a_store_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_ctl.rd_en || st_ctl.wr_en) |-> !in_ch.ready)
		else $error("store access while idle");

	// a new result only appears after a transaction was in work
	a_out_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(!in_ch.ready))
		else $error("result raised without a transaction in work");

endmodule

// ===== src/fba_cfg.sv =====
// ----------------------------------------------------------------------------
// fba_cfg
// APB register file: placement policy and number of active blocks.
// ----------------------------------------------------------------------------
module fba_cfg import fba_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [1:0] fit_mode_q;
	logic [4:0] blocks_q;
	logic       wr_stb;
	logic       reg_sel;

	assign pready  = 1'b1;
	assign wr_stb  = psel && penable && pwrite;
	assign reg_sel = paddr[PADDR_W-1];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= MODE_FIRST;
			blocks_q   <= BLOCKS_RESET;
		end else if (wr_stb) begin
			case (reg_sel)
				REG_FIT_MODE: fit_mode_q <= pwdata[1:0];
				REG_BLOCKS:   blocks_q   <= pwdata[4:0];
				default:      ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_sel)
			REG_FIT_MODE: prdata = {30'd0, fit_mode_q};
			REG_BLOCKS:   prdata = {27'd0, blocks_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg.fit_mode      = fit_mode_q;
	assign cfg.blocks_in_use = blocks_q;

endmodule

// ===== src/fba_store.sv =====
// ----------------------------------------------------------------------------
// fba_store
// Block free-capacity memory: one write port, one registered read port.
// Per-entry valid bits make never-loaded blocks read as zero after reset.
// ----------------------------------------------------------------------------
module fba_store import fba_pkg::*; #(
	parameter  int NUM_BLOCKS = 16,
	parameter  int SIZE_BITS  = 16,
	localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  store_ctl_t           ctl,
	input  logic [IDX_W-1:0]     rd_addr,
	input  logic [IDX_W-1:0]     wr_addr,
	input  logic [SIZE_BITS-1:0] wr_data,
	output logic [SIZE_BITS-1:0] rd_data
);

	logic [SIZE_BITS-1:0]  mem_q [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] valid_q;
	logic [SIZE_BITS-1:0]  rd_data_q;

	// valid bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// storage and registered read
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem_q[rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/fba_seq.sv =====
// ----------------------------------------------------------------------------
// fba_seq
// Sequencer with one shared fit compare unit. An allocate scans the active
// blocks one per cycle keeping the pick, then writes back and holds the result.
// ----------------------------------------------------------------------------
module fba_seq import fba_pkg::*; #(
	parameter  int NUM_BLOCKS = 16,
	parameter  int SIZE_BITS  = 16,
	localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	fba_in_if.sink               in_ch,
	fba_out_if.source            out_ch,
	input  cfg_t                 cfg,
	output store_ctl_t           st_ctl,
	output logic [IDX_W-1:0]     rd_addr,
	output logic [IDX_W-1:0]     wr_addr,
	output logic [SIZE_BITS-1:0] wr_data,
	input  logic [SIZE_BITS-1:0] rd_data
);

	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
	localparam int CMP_W = (SIZE_BITS > SIZE_IN_W) ? SIZE_BITS : SIZE_IN_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_UPD,
		S_DONE
	} state_t;

	state_t                state_q;
	logic                  cmd_q;
	logic [BLK_W-1:0]      idx_q;
	logic [SIZE_IN_W-1:0]  size_q;
	logic [CNT_W-1:0]      active_q;
	logic [CNT_W-1:0]      rd_cnt_q;
	logic                  cmp_vld_q;
	logic [IDX_W-1:0]      cmp_idx_q;
	logic                  found_q;
	logic [IDX_W-1:0]      pick_q;
	logic [SIZE_BITS-1:0]  pick_cap_q;
	status_t               res_status_q;
	logic [BLK_W-1:0]      res_blk_q;
	logic [SIZE_IN_W-1:0]  res_rem_q;
	logic                  out_vld_q;
	status_t               out_status_q;
	logic [BLK_W-1:0]      out_blk_q;
	logic [SIZE_IN_W-1:0]  out_rem_q;

	logic                  rd_more;
	logic [CNT_W-1:0]      active_clamp;
	logic [CMP_W-1:0]      cap_x;
	logic [CMP_W-1:0]      size_x;
	logic [CMP_W-1:0]      pick_x;
	logic                  fits;
	logic                  better;
	logic                  take;
	logic                  load_ok;
	logic [SIZE_BITS-1:0]  new_cap;

	// active block count, clamped to the store depth
	assign active_clamp = (32'(cfg.blocks_in_use) > NUM_BLOCKS) ?
		CNT_W'(NUM_BLOCKS) : CNT_W'(cfg.blocks_in_use);

	assign rd_more = rd_cnt_q < active_q;
	assign load_ok = 32'(idx_q) < NUM_BLOCKS;

	// shared fit compare unit
	assign cap_x  = CMP_W'(rd_data);
	assign size_x = CMP_W'(size_q);
	assign pick_x = CMP_W'(pick_cap_q);
	assign fits   = cap_x >= size_x;

	always_comb begin
		case (cfg.fit_mode)
			MODE_BEST:  better = cap_x < pick_x;
			MODE_WORST: better = cap_x > pick_x;
			default:    better = 1'b0;
		endcase
	end

	assign take    = cmp_vld_q && fits && (!found_q || better);
	assign new_cap = SIZE_BITS'(pick_x - size_x);

	// store port
	assign st_ctl.rd_en = (state_q == S_SCAN) && rd_more;
	assign st_ctl.wr_en = (state_q == S_UPD) && ((cmd_q == CMD_LOAD) ? load_ok : found_q);
	assign rd_addr      = IDX_W'(rd_cnt_q);
	assign wr_addr      = (cmd_q == CMD_LOAD) ? IDX_W'(idx_q) : pick_q;
	assign wr_data      = (cmd_q == CMD_LOAD) ? SIZE_BITS'(size_q) : new_cap;

	// channels
	assign in_ch.ready         = (state_q == S_IDLE);
	assign out_ch.valid        = out_vld_q;
	assign out_ch.status       = out_status_q;
	assign out_ch.chosen_block = out_blk_q;
	assign out_ch.remaining    = out_rem_q;

	// sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
			cmp_vld_q <= 1'b0;
			found_q   <= 1'b0;
			rd_cnt_q  <= '0;
			active_q  <= '0;
		end else begin
			// result taken; the final step reloads the register itself
			if (out_vld_q && out_ch.ready && (state_q != S_DONE)) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						cmd_q     <= in_ch.cmd;
						idx_q     <= in_ch.block_index;
						size_q    <= in_ch.size_value;
						rd_cnt_q  <= '0;
						found_q   <= 1'b0;
						cmp_vld_q <= 1'b0;
						active_q  <= active_clamp;
						state_q   <= (in_ch.cmd == CMD_LOAD) ? S_UPD : S_SCAN;
					end
				end
				S_SCAN: begin
					cmp_vld_q <= rd_more;
					cmp_idx_q <= IDX_W'(rd_cnt_q);
					if (rd_more) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (take) begin
						found_q    <= 1'b1;
						pick_q     <= cmp_idx_q;
						pick_cap_q <= rd_data;
					end
					if (!rd_more && !cmp_vld_q) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (cmd_q == CMD_LOAD) begin
						res_status_q <= ST_LOAD;
						res_blk_q    <= idx_q;
						res_rem_q    <= load_ok ? SIZE_IN_W'(SIZE_BITS'(size_q)) : '0;
					end else if (found_q) begin
						res_status_q <= ST_ALLOC;
						res_blk_q    <= BLK_W'(pick_q);
						res_rem_q    <= SIZE_IN_W'(new_cap);
					end else begin
						res_status_q <= ST_NOFIT;
						res_blk_q    <= '0;
						res_rem_q    <= '0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_vld_q || out_ch.ready) begin
						out_vld_q    <= 1'b1;
						out_status_q <= res_status_q;
						out_blk_q    <= res_blk_q;
						out_rem_q    <= res_rem_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
